// ===== design/drcb_pkg.sv =====
// ----------------------------------------------------------------------------
// drcb_pkg: shared types and constants for distance ring cell bucketing
// widths, register indexes, queue entry and status structs
// ----------------------------------------------------------------------------
package drcb_pkg;

  localparam int MAX_RING    = 100;
  localparam int RING_CNT    = MAX_RING + 1;
  localparam int RING_W      = 7;
  localparam int FILL_W      = 11;
  localparam int SLOT_W      = 16;
  localparam int CELL_W      = 6;
  localparam int GRID_W      = 7;
  localparam int ORG_W       = 16;
  localparam int DIFF_W      = ORG_W + 1;
  localparam int SQ_W        = 32;
  localparam int RAD_W       = SQ_W + 1 - 16;
  localparam int ROOT_W      = RAD_W + 1;
  localparam int BASE_MUL_W  = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int CFG_IDX_W   = 2;

  localparam logic [GRID_W-1:0] GRID_MAX   = 7'd64;
  localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

  // first trial bit of the square root, highest even power in range
  localparam logic [RAD_W-1:0] ROOT_BIT0 = {1'b1, {(RAD_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd2;

  typedef struct packed {
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_z;
    logic [GRID_W-1:0] grid_size;
  } drcb_cfg_t;

  typedef struct packed {
    logic              frame_start;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              in_ring;
    logic [RING_W-1:0] ring;
    logic [SLOT_W-1:0] base;
  } drcb_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } drcb_q_stat_t;

endpackage

// ===== design/drcb_channels_if.sv =====
// ----------------------------------------------------------------------------
// drcb channels: valid/ready interfaces for cells in and bucket results out
// one transaction at each edge with valid and ready high
// ----------------------------------------------------------------------------
interface drcb_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [5:0] cell_x;
  logic [5:0] cell_y;

  modport source (output valid, output frame_start, output cell_x, output cell_y,
                  input ready);
  modport sink   (input valid, input frame_start, input cell_x, input cell_y,
                  output ready);
endinterface

interface drcb_out_if;
  logic        valid;
  logic        ready;
  logic        in_ring;
  logic        ring_full;
  logic [6:0]  ring_number;
  logic [15:0] slot_index;
  logic [5:0]  echo_x;
  logic [5:0]  echo_y;

  modport source (output valid, output in_ring, output ring_full, output ring_number,
                  output slot_index, output echo_x, output echo_y, input ready);
  modport sink   (input valid, input in_ring, input ring_full, input ring_number,
                  input slot_index, input echo_x, input echo_y, output ready);
endinterface

// ===== design/drcb_ram.sv =====
// ----------------------------------------------------------------------------
// drcb_ram: generic single write port ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module drcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/drcb_queue.sv =====
// ----------------------------------------------------------------------------
// drcb_queue: short fifo between the classify front and the counter back
// lets either side stall on its own
// ----------------------------------------------------------------------------
module drcb_queue import drcb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  drcb_item_t   push_item,
  input  logic         pop,
  output drcb_item_t   head,
  output drcb_q_stat_t stat
);

  drcb_item_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = entry_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // depth is a power of two, pointers wrap naturally
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/drcb_front.sv =====
// ----------------------------------------------------------------------------
// drcb_front: takes a cell, squares its offsets, finds the ring
// nine step restoring square root, then ring base offset into the queue
// ----------------------------------------------------------------------------
module drcb_front import drcb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  drcb_in_if.sink      in_ch,
  input  drcb_cfg_t    cfg,
  input  drcb_q_stat_t q_stat,
  output logic         push,
  output drcb_item_t   push_item
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_ROOT = 3'd3;
  localparam logic [2:0] F_BASE = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic                     frame_start_r;
  logic [CELL_W-1:0]        cell_x_r, cell_y_r;
  logic                     in_grid_r;
  logic signed [DIFF_W-1:0] dx_r, dz_r;
  logic [SQ_W-1:0]          sqx_r, sqz_r;
  logic [RAD_W-1:0]         rem_r, bit_r;
  logic [ROOT_W-1:0]        res_r;
  logic                     in_ring_r;
  logic [RING_W-1:0]        ring_r;
  logic [SLOT_W-1:0]        base_r;

  logic                       accept;
  logic [GRID_W-1:0]          limit;
  logic                       in_grid;
  logic signed [DIFF_W-1:0]   dx, dz;
  logic signed [2*DIFF_W-1:0] px, pz;
  logic [SQ_W:0]              sum;
  logic [ROOT_W:0]            trial, rem_ext;
  logic [RAD_W-1:0]           bit_nxt;
  logic                       root_ok;
  logic [RING_W-1:0]          ring_sel;
  logic [BASE_MUL_W-1:0]      ring_mul;
  logic [RING_W+BASE_MUL_W-1:0] base_prod;

  assign in_ch.ready = (state_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign limit   = (cfg.grid_size < GRID_MAX) ? cfg.grid_size : GRID_MAX;
  assign in_grid = ({1'b0, in_ch.cell_x} < limit) && ({1'b0, in_ch.cell_y} < limit);

  // offsets in q8.8, one extra bit covers the far corner
  assign dx = $signed({cfg.origin_x[ORG_W-1], cfg.origin_x})
            - $signed({(DIFF_W-CELL_W-8)'(0), in_ch.cell_x, 8'h00});
  assign dz = $signed({cfg.origin_z[ORG_W-1], cfg.origin_z})
            - $signed({(DIFF_W-CELL_W-8)'(0), in_ch.cell_y, 8'h00});

  assign px  = dx_r * dx_r;
  assign pz  = dz_r * dz_r;
  assign sum = {1'b0, sqx_r} + {1'b0, sqz_r};

  assign trial   = {1'b0, res_r} + {(ROOT_W+1-RAD_W)'(0), bit_r};
  assign rem_ext = {(ROOT_W+1-RAD_W)'(0), rem_r};
  assign bit_nxt = bit_r >> 2;

  assign root_ok   = in_grid_r && (res_r <= ROOT_W'(MAX_RING));
  assign ring_sel  = root_ok ? res_r[RING_W-1:0] : '0;
  assign ring_mul  = {1'b0, ring_sel, 2'b00} + {2'b00, ring_sel, 1'b0} + BASE_MUL_W'(2);
  assign base_prod = {(BASE_MUL_W)'(0), ring_sel} * {(RING_W)'(0), ring_mul};

  assign push                  = (state_r == F_PUSH);
  assign push_item.frame_start = frame_start_r;
  assign push_item.cell_x      = cell_x_r;
  assign push_item.cell_y      = cell_y_r;
  assign push_item.in_ring     = in_ring_r;
  assign push_item.ring        = ring_r;
  assign push_item.base        = base_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_SUM;
      F_SUM:  state_nxt = F_ROOT;
      F_ROOT: if (bit_nxt == '0) state_nxt = F_BASE;
      F_BASE: state_nxt = F_PUSH;
      F_PUSH: if (!q_stat.full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          frame_start_r <= in_ch.frame_start;
          cell_x_r      <= in_ch.cell_x;
          cell_y_r      <= in_ch.cell_y;
          in_grid_r     <= in_grid;
          dx_r          <= dx;
          dz_r          <= dz;
        end
      end
      F_MUL: begin
        sqx_r <= px[SQ_W-1:0];
        sqz_r <= pz[SQ_W-1:0];
      end
      F_SUM: begin
        rem_r <= sum[SQ_W:16];
        res_r <= '0;
        bit_r <= ROOT_BIT0;
      end
      F_ROOT: begin
        if (rem_ext >= trial) begin
          rem_r <= RAD_W'(rem_ext - trial);
          res_r <= (res_r >> 1) + {(ROOT_W-RAD_W)'(0), bit_r};
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_nxt;
      end
      F_BASE: begin
        in_ring_r <= root_ok;
        ring_r    <= ring_sel;
        base_r    <= base_prod[SLOT_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/drcb_back.sv =====
// ----------------------------------------------------------------------------
// drcb_back: per-ring fill counters, slot assignment and result register
// counters live in a ram, valid bits give the frame clear
// ----------------------------------------------------------------------------
module drcb_back import drcb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  drcb_item_t   head,
  input  drcb_q_stat_t q_stat,
  output logic         pop,
  drcb_out_if.source   out_ch
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_CALC = 1'b1;

  logic state_r, state_nxt;

  drcb_item_t          item_r;
  logic [RING_CNT-1:0] valid_r;
  logic                out_valid_r;
  logic                in_ring_r, ring_full_r;
  logic [RING_W-1:0]   ring_number_r;
  logic [SLOT_W-1:0]   slot_index_r;
  logic [CELL_W-1:0]   echo_x_r, echo_y_r;

  logic [FILL_W-1:0] rd_fill;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] cap;
  logic              full;
  logic              take;
  logic              calc;

  // output register is free or draining, so the result has a home at calc
  assign pop  = (state_r == B_IDLE) && !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign calc = (state_r == B_CALC);

  drcb_ram #(
    .WIDTH(FILL_W),
    .DEPTH(RING_CNT)
  ) u_fill_ram (
    .clk  (clk),
    .we   (calc && take),
    .waddr(item_r.ring),
    .wdata(FILL_W'(fill + 1'b1)),
    .raddr(head.ring),
    .rdata(rd_fill)
  );

  assign fill = valid_r[item_r.ring] ? rd_fill : '0;
  assign cap  = {1'b0, item_r.ring, 3'b000} + {2'b00, item_r.ring, 2'b00} + FILL_W'(8);
  assign full = item_r.in_ring && (fill >= cap);
  assign take = item_r.in_ring && !full;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.in_ring     = in_ring_r;
  assign out_ch.ring_full   = ring_full_r;
  assign out_ch.ring_number = ring_number_r;
  assign out_ch.slot_index  = slot_index_r;
  assign out_ch.echo_x      = echo_x_r;
  assign out_ch.echo_y      = echo_y_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop) state_nxt = B_CALC;
      B_CALC: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && head.frame_start) begin
        valid_r <= '0;
      end else if (calc && take) begin
        valid_r[item_r.ring] <= 1'b1;
      end
      priority if (calc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end else begin
        out_valid_r <= out_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head;
    end
    if (calc) begin
      in_ring_r     <= item_r.in_ring;
      ring_full_r   <= full;
      ring_number_r <= item_r.ring;
      slot_index_r  <= take ? item_r.base + {(SLOT_W-FILL_W)'(0), fill} : '0;
      echo_x_r      <= item_r.cell_x;
      echo_y_r      <= item_r.cell_y;
    end
  end

endmodule

// ===== design/distance_ring_cell_bucketing_core.sv =====
// ----------------------------------------------------------------------------
// distance_ring_cell_bucketing_core: sorts grid cells into distance rings
// computes floor(sqrt) distance from the viewer and hands out ring slots
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake      | payload
//   --------+-----------+----------------+-------------------------------------
//   in_ch   | in        | valid / ready  | frame_start, cell_x, cell_y
//   out_ch  | out       | valid / ready  | in_ring, ring_full, ring_number,
//           |           |                | slot_index, echo_x, echo_y
//   cfg     | in        | cfg_we only    | cfg_index, cfg_wdata
//
// the front takes a new cell only once the last one has gone through the
// nine step square root iteration and been pushed into the queue; a full
// queue holds it in the push state. reset is synchronous active low and
// clears all control state and ring fill valid bits at once, with no
// clearing pass. the queue holds two cells, so the front keeps working
// while the result waits on a stalled sink.
//
module distance_ring_cell_bucketing_core import drcb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  drcb_in_if.sink              in_ch,
  drcb_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ORG_W-1:0]     cfg_wdata
);

  // configuration: the user must write it only while idle, the block itself does not enforce this
  drcb_cfg_t cfg_r, cfg_nxt;

  drcb_item_t   push_item;
  drcb_item_t   head;
  drcb_q_stat_t q_stat;
  logic         push;
  logic         pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:  cfg_nxt.origin_x  = cfg_wdata;
        REG_ORIGIN_Z:  cfg_nxt.origin_z  = cfg_wdata;
        REG_GRID_SIZE: cfg_nxt.grid_size = cfg_wdata[GRID_W-1:0];
        default:       cfg_nxt = cfg_r; // unknown index dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x  <= '0;
      cfg_r.origin_z  <= '0;
      cfg_r.grid_size <= GRID_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: grid check, squared distance, ring and ring base
  drcb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_item(push_item)
  );

  // decoupling queue between classify and counter update
  drcb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back: fill counter read-modify-write and result register
  drcb_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .q_stat(q_stat),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

// ===== design/drcb_checker.sv =====
// ----------------------------------------------------------------------------
// drcb_checker: port level assertions on the result channel
// bound to the core, looks at its ports only
// ----------------------------------------------------------------------------
module drcb_checker import drcb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              in_ring,
  input logic              ring_full,
  input logic [RING_W-1:0] ring_number,
  input logic [SLOT_W-1:0] slot_index
);

  logic [RING_W+BASE_MUL_W-1:0] ring_base;
  logic [RING_W+BASE_MUL_W-1:0] ring_end;

  assign ring_base = {(BASE_MUL_W)'(0), ring_number}
                   * ({(BASE_MUL_W-RING_W)'(0), ring_number} * BASE_MUL_W'(6) + BASE_MUL_W'(2));
  assign ring_end  = ring_base + {(BASE_MUL_W)'(0), ring_number} * (RING_W+BASE_MUL_W)'(12)
                   + (RING_W+BASE_MUL_W)'(8);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(ring_number))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // cells off the grid or past the last ring give an all-zero answer
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_ring |-> !ring_full && ring_number == '0 && slot_index == '0)
    else $error("off-ring result not zero");

  a_ring: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_ring |-> ring_number <= RING_W'(MAX_RING)
                          && (!ring_full || slot_index == '0))
    else $error("bad ring number or slot on full ring");

  // a granted slot lies inside its ring's run
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_ring && !ring_full |->
      {(RING_W+BASE_MUL_W-SLOT_W)'(0), slot_index} >= ring_base
      && {(RING_W+BASE_MUL_W-SLOT_W)'(0), slot_index} < ring_end)
    else $error("slot outside ring run");

endmodule

bind distance_ring_cell_bucketing_core drcb_checker u_drcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .in_ring    (out_ch.in_ring),
  .ring_full  (out_ch.ring_full),
  .ring_number(out_ch.ring_number),
  .slot_index (out_ch.slot_index)
);

// ===== tb/sv/drcb_bucket_checker.sv =====
// ----------------------------------------------------------------------------
// drcb_bucket_checker: ring bucketing predictor and result scoreboard
// watches the cell, result and register ports, works out the ring and slot
// of every accepted cell and compares each result against the oldest one
// ----------------------------------------------------------------------------
module drcb_bucket_checker import drcb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  drcb_in_if                   cells,
  drcb_out_if                  buckets,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ORG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   waiting,
  output int                   slots_given,
  output int                   full_answers
);

  typedef struct packed {
    logic              in_ring;
    logic              ring_full;
    logic [RING_W-1:0] ring_number;
    logic [SLOT_W-1:0] slot_index;
    logic [CELL_W-1:0] echo_x;
    logic [CELL_W-1:0] echo_y;
  } bucket_t;

  drcb_cfg_t         view_cfg;
  logic [FILL_W-1:0] slots_used [RING_CNT];
  bucket_t           expected_buckets [$];
  int                errors = 0;
  int                n_slots = 0;
  int                n_full = 0;

  // exact integer square root, one trial bit at a time from the top
  function automatic int floor_root(input longint v);
    int root;
    int trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (1 << b);
      if (longint'(trial) * longint'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  function automatic bucket_t bucket_cell(input logic new_frame,
                                          input logic [CELL_W-1:0] cx,
                                          input logic [CELL_W-1:0] cy);
    bucket_t b;
    int      lim;
    longint  dx;
    longint  dz;
    int      ring;
    b        = '0;
    b.echo_x = cx;
    b.echo_y = cy;
    if (new_frame) foreach (slots_used[r]) slots_used[r] = '0;
    lim = (int'(view_cfg.grid_size) < int'(GRID_MAX)) ? int'(view_cfg.grid_size)
                                                       : int'(GRID_MAX);
    if (int'(cx) < lim && int'(cy) < lim) begin
      dx   = longint'($signed(view_cfg.origin_x)) - 256 * longint'(cx);
      dz   = longint'($signed(view_cfg.origin_z)) - 256 * longint'(cy);
      ring = floor_root((dx * dx + dz * dz) >>> 16);
      if (ring <= MAX_RING) begin
        b.in_ring     = 1'b1;
        b.ring_number = RING_W'(ring);
        if (int'(slots_used[ring]) >= 12 * ring + 8) begin
          b.ring_full = 1'b1;
        end else begin
          b.slot_index     = SLOT_W'(ring * (6 * ring + 2) + int'(slots_used[ring]));
          slots_used[ring] = slots_used[ring] + 1'b1;
        end
      end
    end
    return b;
  endfunction

  function automatic string show(input bucket_t b);
    return $sformatf("in_ring=%0b full=%0b ring=%0d slot=%0d x=%0d y=%0d",
                     b.in_ring, b.ring_full, b.ring_number, b.slot_index,
                     b.echo_x, b.echo_y);
  endfunction

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    bucket_t got;
    bucket_t want;
    if (!rst_n) begin
      view_cfg.origin_x  = '0;
      view_cfg.origin_z  = '0;
      view_cfg.grid_size = GRID_RESET;
      foreach (slots_used[r]) slots_used[r] = '0;
      expected_buckets.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:  view_cfg.origin_x  = cfg_wdata;
          REG_ORIGIN_Z:  view_cfg.origin_z  = cfg_wdata;
          REG_GRID_SIZE: view_cfg.grid_size = cfg_wdata[GRID_W-1:0];
          default: ;
        endcase
      end
      // results first: a result never belongs to a cell taken at the same edge
      if (buckets.valid && buckets.ready) begin
        got.in_ring     = buckets.in_ring;
        got.ring_full   = buckets.ring_full;
        got.ring_number = buckets.ring_number;
        got.slot_index  = buckets.slot_index;
        got.echo_x      = buckets.echo_x;
        got.echo_y      = buckets.echo_y;
        if (expected_buckets.size() == 0) begin
          note_failure($sformatf("unexpected result: %s", show(got)));
        end else begin
          want = expected_buckets.pop_front();
          if (got.in_ring !== want.in_ring || got.ring_full !== want.ring_full ||
              got.ring_number !== want.ring_number ||
              got.slot_index !== want.slot_index ||
              got.echo_x !== want.echo_x || got.echo_y !== want.echo_y)
            note_failure($sformatf("result mismatch: expected %s, got %s",
                                   show(want), show(got)));
          if (want.ring_full) n_full++;
          else if (want.in_ring) n_slots++;
        end
      end
      if (cells.valid && cells.ready)
        expected_buckets.push_back(bucket_cell(cells.frame_start, cells.cell_x,
                                               cells.cell_y));
    end
    mismatches   <= errors;
    waiting      <= expected_buckets.size();
    slots_given  <= n_slots;
    full_answers <= n_full;
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: distance ring cell bucketing testbench
// directed cells for the corner cases, then random frames of cells under a
// series of viewer and grid settings, checked by drcb_bucket_checker
// ----------------------------------------------------------------------------
module tb;
  import drcb_pkg::*;

  localparam int RANDOM_CELLS  = 1625;
  localparam int CALM_FIRST    = 700;     // no idling on either side in here
  localparam int CALM_LAST     = 1000;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;

  // index with no register behind it, the block should ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ORG_W-1:0]     cfg_wdata;

  drcb_in_if  in_ch ();
  drcb_out_if out_ch ();

  int   mismatches;
  int   waiting;
  int   slots_given;
  int   full_answers;
  int   cycles = 0;
  int   cells_sent;
  int   settings_used;
  bit   idle_on;
  int   grid_lim;
  logic [ORG_W-1:0] view_x;
  logic [ORG_W-1:0] view_z;

  always #5 clk = ~clk;

  distance_ring_cell_bucketing_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  drcb_bucket_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cells        (in_ch),
    .buckets      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .waiting      (waiting),
    .slots_given  (slots_given),
    .full_answers (full_answers)
  );

  // result side back-pressure, ready dropped at random about a tenth of the time outside the calm stretch
  always @(posedge clk) begin
    out_ch.ready <= !(idle_on && $urandom_range(99) < 10);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // one cell transaction, with an occasional random gap before it so that
  // idle cycles land on every step of the square root
  task automatic send_cell(input bit fs, input int x, input int y);
    int gap;
    gap = 0;
    idle_on <= !(cells_sent >= CALM_FIRST && cells_sent < CALM_LAST);
    if (idle_on && $urandom_range(99) < 10) gap = $urandom_range(20, 1);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.frame_start <= fs;
    in_ch.cell_x      <= CELL_W'(x);
    in_ch.cell_y      <= CELL_W'(y);
    do @(posedge clk); while (!in_ch.ready);
    cells_sent++;
  endtask

  // hold the cell side off until every result in flight has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // new viewer position and grid size, only ever with the block empty
  task automatic load_view(input logic [ORG_W-1:0] ox, input logic [ORG_W-1:0] oz,
                           input logic [ORG_W-1:0] gdata, input bit poke_spare);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_wdata <= ox;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Z;
    cfg_wdata <= oz;
    @(posedge clk);
    cfg_index <= REG_GRID_SIZE;
    cfg_wdata <= gdata;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= ORG_W'($urandom);
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    view_x    = ox;
    view_z    = oz;
    grid_lim  = (int'(gdata[GRID_W-1:0]) < int'(GRID_MAX)) ? int'(gdata[GRID_W-1:0])
                                                           : int'(GRID_MAX);
    settings_used++;
  endtask

  // mostly near or over the grid, now and then one of the extremes
  function automatic logic [ORG_W-1:0] pick_origin();
    case ($urandom_range(19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return ORG_W'(int'($urandom_range(18432)) - 2048);
    endcase
  endfunction

  // a cell at or next to the viewer, so that the small rings fill up
  function automatic int near_cell(input logic [ORG_W-1:0] org);
    int c;
    int top;
    top = (grid_lim > 0) ? grid_lim - 1 : 63;
    c   = $signed(org) >>> 8;
    c   = c + int'($urandom_range(2)) - 1;
    if (c < 0) c = 0;
    if (c > top) c = top;
    return c;
  endfunction

  // frames of cells under the current settings: mostly well-formed frames
  // opened by frame_start, some cells piled around the viewer, some noise
  task automatic run_frames(input int n_cells);
    int done;
    int frame_len;
    int pick;
    int x;
    int y;
    bit fs;
    done = 0;
    while (done < n_cells) begin
      frame_len = $urandom_range(80, 4);
      for (int k = 0; k < frame_len && done < n_cells; k++) begin
        pick = $urandom_range(99);
        fs   = (k == 0);
        if (pick < 60) begin
          x = (grid_lim > 0) ? $urandom_range(grid_lim - 1) : $urandom_range(63);
          y = (grid_lim > 0) ? $urandom_range(grid_lim - 1) : $urandom_range(63);
        end else if (pick < 88) begin
          x = near_cell(view_x);
          y = near_cell(view_z);
        end else begin
          x  = $urandom_range(63);
          y  = $urandom_range(63);
          fs = $urandom_range(1);
        end
        send_cell(fs, x, y);
        done++;
      end
    end
  endtask

  initial begin
    logic [GRID_W-1:0] gs;
    int                target;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_ORIGIN_X;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.frame_start = 1'b0;
    in_ch.cell_x      = '0;
    in_ch.cell_y      = '0;
    out_ch.ready      = 1'b0;
    idle_on           = 1'b1;
    cells_sent        = 0;
    settings_used     = 1;
    grid_lim          = 64;
    view_x            = '0;
    view_z            = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // settings straight out of reset: viewer at the grid corner, full grid
    send_cell(1'b1, 0, 0);        // ring 0, first slot
    send_cell(1'b0, 63, 63);      // far corner, ring 89
    send_cell(1'b0, 63, 0);
    send_cell(1'b0, 0, 63);
    // ring 0 has eight slots: seven more fit, the last one finds it full
    repeat (8) send_cell(1'b0, 0, 0);
    send_cell(1'b1, 0, 0);        // new frame clears the counters again

    // viewer at the most negative x and most positive z, grid size clamped
    load_view(16'h8000, 16'h7fff, 16'h007f, 1'b0);
    send_cell(1'b1, 0, 0);        // every cell beyond the last ring
    send_cell(1'b0, 63, 63);

    // empty grid: everything is outside
    load_view(16'h2080, 16'h0000, 16'h0000, 1'b0);
    send_cell(1'b1, 0, 0);
    send_cell(1'b0, 63, 63);

    // small grid around a viewer in the middle of a cell, plus a stray write
    load_view(16'h0580, 16'h0580, 16'h000a, 1'b1);
    send_cell(1'b1, 10, 3);       // just past the grid edge
    send_cell(1'b0, 3, 10);
    send_cell(1'b0, 9, 9);
    send_cell(1'b0, 5, 5);
    send_cell(1'b0, 6, 6);

    // viewer 37 cells left of the grid: the far column sits on the last ring
    load_view(16'hdb00, 16'h0000, 16'h0040, 1'b0);
    send_cell(1'b1, 63, 0);       // ring 100 exactly
    send_cell(1'b0, 63, 1);       // still ring 100, next slot
    send_cell(1'b0, 63, 15);      // ring 101, past the limit

    // random part, a fresh viewer and grid per block of frames
    target = cells_sent + RANDOM_CELLS;
    while (cells_sent < target) begin
      case ($urandom_range(9))
        0:       gs = 7'd0;
        1, 2:    gs = GRID_W'($urandom_range(127, 65));
        3, 4:    gs = GRID_W'($urandom_range(63, 1));
        default: gs = GRID_MAX;
      endcase
      load_view(pick_origin(), pick_origin(), {9'($urandom), gs}, $urandom_range(3) == 0);
      run_frames((target - cells_sent < 200) ? target - cells_sent
                                             : $urandom_range(200, 60));
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d cells under %0d viewer and grid settings", cells_sent,
             settings_used);
    $display("%0d slots handed out, %0d cells refused by a full ring", slots_given,
             full_answers);
    if (mismatches == 0 && waiting == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
